[rtl/c_subset_token_lexer_macros.svh]
// Assertion macros for the lexer top level.
`ifndef C_SUBSET_TOKEN_LEXER_MACROS_SVH
`define C_SUBSET_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CTSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CTSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ctsl_pkg.sv]
// Types, codes and character tables for the C subset token lexer.
package ctsl_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [3:0] {
      KIND_LPAREN = 4'd0,
      KIND_RPAREN = 4'd1,
      KIND_LBRACE = 4'd2,
      KIND_RBRACE = 4'd3,
      KIND_SEMI   = 4'd4,
      KIND_CONST  = 4'd5,
      KIND_IDENT  = 4'd6,
      KIND_RETURN = 4'd7,
      KIND_VOID   = 4'd8,
      KIND_INT    = 4'd9,
      KIND_ERROR  = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NO_MATCH = 2'd1,
      ERR_BAD_NEXT = 2'd2,
      ERR_OPEN_END = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_PUNCT,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_OTHER
   } cls_type;

   // keyword slots, also the bit positions of the candidate mask
   localparam logic [1:0] KW_RETURN = 2'd0;
   localparam logic [1:0] KW_VOID   = 2'd1;
   localparam logic [1:0] KW_INT    = 2'd2;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [1:0]  error_code;
      logic [15:0] value_start;
      logic [15:0] value_length;
      logic [7:0]  offending_byte;
      logic        last_of_run;
   } rsp_type;

   // what one source byte produces: one result, optionally followed by a punctuation token
   typedef struct packed {
      rsp_type    first;
      logic       two;
      logic [3:0] second_kind;
   } entry_type;

   function automatic cls_type classify(input logic [7:0] c);
      cls_type r;
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) r = CLS_SPACE;
      else if (c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D || c == 8'h3B)
         r = CLS_PUNCT;
      else if (c >= 8'h30 && c <= 8'h39) r = CLS_DIGIT;
      else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F)
         r = CLS_ALPHA;
      else r = CLS_OTHER;
      return r;
   endfunction

   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type r;
      case (c)
         8'h28:   r = KIND_LPAREN;
         8'h29:   r = KIND_RPAREN;
         8'h7B:   r = KIND_LBRACE;
         8'h7D:   r = KIND_RBRACE;
         default: r = KIND_SEMI;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] kw_len(input logic [1:0] k);
      logic [15:0] r;
      case (k)
         KW_RETURN: r = 16'd6;
         KW_VOID:   r = 16'd4;
         default:   r = 16'd3;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
      logic [7:0] r;
      r = 8'h00;
      case (k)
         KW_RETURN: begin
            case (pos)
               3'd0:    r = 8'h72;
               3'd1:    r = 8'h65;
               3'd2:    r = 8'h74;
               3'd3:    r = 8'h75;
               3'd4:    r = 8'h72;
               3'd5:    r = 8'h6E;
               default: r = 8'h00;
            endcase
         end
         KW_VOID: begin
            case (pos)
               3'd0:    r = 8'h76;
               3'd1:    r = 8'h6F;
               3'd2:    r = 8'h69;
               3'd3:    r = 8'h64;
               default: r = 8'h00;
            endcase
         end
         default: begin
            case (pos)
               3'd0:    r = 8'h69;
               3'd1:    r = 8'h6E;
               3'd2:    r = 8'h74;
               default: r = 8'h00;
            endcase
         end
      endcase
      return r;
   endfunction

endpackage

[rtl/ctsl_front.sv]
// Front end: classifies each source byte, tracks the open run and builds queue entries.
module ctsl_front import ctsl_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   output logic      full,
   input  req_type   req_data,
   output logic      q_push,
   output entry_type q_entry,
   input  logic      q_full
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_CONST,
      MODE_IDENT
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] begin_ff, begin_in;
   logic [15:0]            count_ff, count_in;
   logic [2:0]             cand_ff, cand_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   skip_ff, skip_in;

   cls_type     cls;
   logic        accept;
   logic        extends_run;
   logic        err;
   logic [15:0] base_count;
   logic [15:0] grown_count;
   logic [2:0]  base_cand;
   logic [2:0]  grown_cand;
   kind_type    run_kind;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign cls    = classify(req_data.src_byte);

   // keyword filter for a byte that opens or extends a run
   always_comb begin
      base_count = (mode_ff == MODE_IDLE) ? 16'd0 : count_ff;
      base_cand  = (mode_ff == MODE_IDLE) ? 3'b111 : cand_ff;
      grown_cand = base_cand;
      for (int k = 0; k < 3; k++) begin
         if (base_cand[k] && (base_count >= kw_len(2'(k)) ||
             kw_char(2'(k), base_count[2:0]) != req_data.src_byte)) begin
            grown_cand[k] = 1'b0;
         end
      end
      grown_count = (base_count == 16'hFFFF) ? base_count : base_count + 16'd1;
   end

   always_comb begin
      if (mode_ff == MODE_CONST) run_kind = KIND_CONST;
      else if (cand_ff[KW_RETURN] && count_ff == kw_len(KW_RETURN)) run_kind = KIND_RETURN;
      else if (cand_ff[KW_VOID] && count_ff == kw_len(KW_VOID)) run_kind = KIND_VOID;
      else if (cand_ff[KW_INT] && count_ff == kw_len(KW_INT)) run_kind = KIND_INT;
      else run_kind = KIND_IDENT;
   end

   always_comb begin
      mode_in     = mode_ff;
      begin_in    = begin_ff;
      count_in    = count_ff;
      cand_in     = cand_ff;
      offset_in   = offset_ff;
      skip_in     = skip_ff;
      err         = 1'b0;
      q_push      = 1'b0;
      q_entry     = '0;
      extends_run = (cls == CLS_DIGIT) || (mode_ff == MODE_IDENT && cls == CLS_ALPHA);

      if (accept && !skip_ff) begin
         if (mode_ff != MODE_IDLE) begin
            if (extends_run) begin
               count_in = grown_count;
               cand_in  = grown_cand;
               if (req_data.end_of_source) begin
                  q_push                      = 1'b1;
                  q_entry.first.token_kind    = KIND_ERROR;
                  q_entry.first.error_code    = ERR_OPEN_END;
                  err                         = 1'b1;
               end
            end else if (cls == CLS_SPACE || cls == CLS_PUNCT) begin
               q_push                   = 1'b1;
               q_entry.first.token_kind = run_kind;
               if (run_kind == KIND_CONST || run_kind == KIND_IDENT) begin
                  q_entry.first.value_start  = 16'(begin_ff);
                  q_entry.first.value_length = count_ff;
               end
               q_entry.two         = (cls == CLS_PUNCT);
               q_entry.second_kind = punct_kind(req_data.src_byte);
               mode_in  = MODE_IDLE;
               begin_in = '0;
               count_in = '0;
               cand_in  = 3'b111;
            end else begin
               q_push                       = 1'b1;
               q_entry.first.token_kind     = KIND_ERROR;
               q_entry.first.error_code     = ERR_BAD_NEXT;
               q_entry.first.offending_byte = req_data.src_byte;
               err      = 1'b1;
               mode_in  = MODE_IDLE;
               begin_in = '0;
               count_in = '0;
               cand_in  = 3'b111;
            end
         end else begin
            case (cls)
               CLS_PUNCT: begin
                  q_push                   = 1'b1;
                  q_entry.first.token_kind = punct_kind(req_data.src_byte);
               end
               CLS_DIGIT, CLS_ALPHA: begin
                  mode_in  = (cls == CLS_DIGIT) ? MODE_CONST : MODE_IDENT;
                  begin_in = offset_ff;
                  count_in = grown_count;
                  cand_in  = grown_cand;
                  if (req_data.end_of_source) begin
                     q_push                   = 1'b1;
                     q_entry.first.token_kind = KIND_ERROR;
                     q_entry.first.error_code = ERR_OPEN_END;
                     err                      = 1'b1;
                  end
               end
               CLS_OTHER: begin
                  q_push                       = 1'b1;
                  q_entry.first.token_kind     = KIND_ERROR;
                  q_entry.first.error_code     = ERR_NO_MATCH;
                  q_entry.first.offending_byte = req_data.src_byte;
                  err                          = 1'b1;
               end
               default: begin
               end
            endcase
         end

         if (offset_ff != '1) offset_in = offset_ff + OFFSET_BITS'(1);
         if (err) skip_in = 1'b1;
      end

      q_entry.first.last_of_run = !q_entry.two;

      // the last byte of a source puts everything back to the start state
      if (accept && req_data.end_of_source) begin
         mode_in   = MODE_IDLE;
         begin_in  = '0;
         count_in  = '0;
         cand_in   = 3'b111;
         offset_in = '0;
         skip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         begin_ff  <= '0;
         count_ff  <= '0;
         cand_ff   <= 3'b111;
         offset_ff <= '0;
         skip_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         begin_ff  <= begin_in;
         count_ff  <= count_in;
         cand_ff   <= cand_in;
         offset_ff <= offset_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

[rtl/ctsl_queue.sv]
// Small ring queue of entries between the front and back ends.
module ctsl_queue import ctsl_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output entry_type rd_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_rd) rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_wr && !do_rd) count_in = count_ff + CNT_W'(1);
      else if (do_rd && !do_wr) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/ctsl_back.sv]
// Back end: expands queue entries into result items behind an output register.
module ctsl_back import ctsl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  entry_type q_entry,
   output logic      q_pop,
   output logic      empty,
   input  logic      pop,
   output rsp_type   rsp_data
);

   rsp_type out_ff;
   logic    valid_ff;
   logic    second_ff;

   rsp_type next_rsp;
   logic    load;
   logic    last_part;

   always_comb begin
      next_rsp = q_entry.first;
      if (second_ff) begin
         next_rsp             = '0;
         next_rsp.token_kind  = q_entry.second_kind;
         next_rsp.last_of_run = 1'b1;
      end
   end

   assign last_part = second_ff || !q_entry.two;
   assign load      = !q_empty && (!valid_ff || pop);
   assign q_pop     = load && last_part;
   assign empty     = !valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (load) out_ff <= next_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (load) begin
         valid_ff  <= 1'b1;
         second_ff <= !last_part;
      end else if (pop) begin
         valid_ff  <= 1'b0;
      end
   end

endmodule

[rtl/c_subset_token_lexer.sv]
// C subset token lexer: one source byte per cycle in while not full, token items out.
// Throughput: one byte accepted per cycle while the queue is not full; a byte closing a
//   run before punctuation gives two items, which leave in turn through the single output register.
// The first item of a byte passes through the entry queue, then the output register, to rsp.
// Reset: synchronous, clears run state, offset, skip flag, entry queue and output valid state.
`include "c_subset_token_lexer_macros.svh"

module c_subset_token_lexer import ctsl_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;
   entry_type q_wr_entry;
   entry_type q_rd_entry;

   logic      rsp_code_ok;
   logic      rsp_mid;
   logic      rsp_run;
   logic      rsp_tail;

   ctsl_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_wr_entry),
      .q_full   (q_full)
   );

   ctsl_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_entry),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_entry),
      .empty   (q_empty)
   );

   ctsl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_entry  (q_rd_entry),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   assign rsp_code_ok = (rsp_data.token_kind == KIND_ERROR) == (rsp_data.error_code != ERR_NONE);
   assign rsp_mid     = !empty && !rsp_data.last_of_run;
   assign rsp_run     = (rsp_data.token_kind == KIND_CONST) ||
                        (rsp_data.token_kind == KIND_IDENT) ||
                        (rsp_data.token_kind == KIND_RETURN) ||
                        (rsp_data.token_kind == KIND_VOID) ||
                        (rsp_data.token_kind == KIND_INT);
   assign rsp_tail    = !empty && rsp_data.last_of_run && (rsp_data.token_kind <= KIND_SEMI);

   `CTSL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty, "output not empty after reset")

   `CTSL_ASSERT_NOW(a_error_code, clock, reset, !empty, rsp_code_ok, "error kind/code mismatch")

   `CTSL_ASSERT_NOW(a_pair_head, clock, reset, rsp_mid, rsp_run, "non-final item not a run token")

   `CTSL_ASSERT_NEXT(a_pair_tail, clock, reset, rsp_mid && pop, rsp_tail, "pair tail not punctuation")

endmodule
